// ===== design/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and constants of the prescaled alarm timer: request kinds,
// register numbers, control register layout and the response layout.
// ----------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

   // Default counter width
   localparam int COUNT_WIDTH_DEF = 32;

   // Bus and field widths
   localparam int DATA_WIDTH    = 32;
   localparam int OP_WIDTH      = 2;
   localparam int SEL_WIDTH     = 3;
   localparam int REQ_USER_W    = OP_WIDTH + SEL_WIDTH;
   localparam int RSP_DATA_W    = 40;
   localparam int PHASE_WIDTH   = 8;
   localparam int DIV_WIDTH     = 3;

   // Request kinds
   localparam logic [OP_WIDTH-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_READ  = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_WRITE = 2'd2;

   // Register numbers
   localparam logic [SEL_WIDTH-1:0] REG_LOAD   = 3'd0;
   localparam logic [SEL_WIDTH-1:0] REG_COUNT  = 3'd1;
   localparam logic [SEL_WIDTH-1:0] REG_CTRL   = 3'd2;
   localparam logic [SEL_WIDTH-1:0] REG_ALARM  = 3'd3;
   localparam logic [SEL_WIDTH-1:0] REG_INTCLR = 3'd4;

   // Divider codes
   localparam logic [DIV_WIDTH-1:0] DIV_1   = 3'd0;
   localparam logic [DIV_WIDTH-1:0] DIV_16  = 3'd2;
   localparam logic [DIV_WIDTH-1:0] DIV_256 = 3'd4;

   // Prescaler terminal counts (phase + 1 reaching these rolls over)
   localparam logic [PHASE_WIDTH:0] PRE_16  = 9'd16;
   localparam logic [PHASE_WIDTH:0] PRE_256 = 9'd256;

   // Control register bit positions
   localparam int CTRL_LEVEL  = 0;
   localparam int CTRL_DIV_LO = 1;
   localparam int CTRL_AUTO   = 6;
   localparam int CTRL_EN     = 7;
   localparam int CTRL_STAT   = 8;

   // Interrupt clear bit
   localparam int INTCLR_BIT = 0;

   // Response payload, rdata in the low bits
   typedef struct packed {
      logic                  irq_pulse;
      logic                  irq_level;
      logic [DATA_WIDTH-1:0] rdata;
   } rsp_type;

   localparam int RSP_PAD_W = RSP_DATA_W - $bits(rsp_type);

endpackage

`default_nettype wire

// ===== design/prescaled_alarm_timer.sv =====
// ----------------------------------------------------------------------------
// prescaled_alarm_timer
// Wrapping up-counter with a 1/16/256 prescaler, an alarm compare and a
// level or edge interrupt, driven by a stream of tick and register requests.
// ----------------------------------------------------------------------------
// Each request (a clock tick, a register read or a register write) gives one
// response. Responses sit in an output register backed by a one-entry skid
// stage that takes a response behind a stalled one, so a stalled response
// side still lets one more request in before req_tready drops. A new request
// can be taken every cycle while the skid stage is empty; the rate is set by
// the combinational update of prescaler, counter increment and alarm compare.
// Registers: 0 load, 1 count (read only), 2 control, 3 alarm, 4 interrupt
// clear. Control: bit 0 level mode, bits 3..1 divider (2 = /16, 4 = /256,
// else /1), bit 6 auto rearm, bit 7 enable, bit 8 status (read only).
`default_nettype none

module prescaled_alarm_timer
   import pat_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [DATA_WIDTH-1:0] req_tdata,  // [31:0] wdata
   input  wire logic [REQ_USER_W-1:0] req_tuser,  // [1:0] op, [4:2] reg_sel
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata   // [31:0] rdata, [32] irq_level,
                                                  // [33] irq_pulse, [39:34] zero
);

   // Timer state
   logic [COUNT_WIDTH-1:0] counter_ff,   counter_in;
   logic [PHASE_WIDTH-1:0] phase_ff,     phase_in;
   logic [DATA_WIDTH-1:0]  load_ff,      load_in;
   logic [DATA_WIDTH-1:0]  alarm_ff,     alarm_in;
   logic                   enable_ff,    enable_in;
   logic                   level_ff,     level_in;
   logic                   auto_ff,      auto_in;
   logic [DIV_WIDTH-1:0]   div_ff,       div_in;
   logic                   status_ff,    status_in;
   logic                   armed_ff,     armed_in;

   // Output register and skid stage
   logic                   main_vld_ff,  main_vld_in;
   logic                   skid_vld_ff,  skid_vld_in;
   rsp_type                main_ff,      main_in;
   rsp_type                skid_ff,      skid_in;

   logic [OP_WIDTH-1:0]    op;
   logic [SEL_WIDTH-1:0]   sel;
   logic                   req_fire;
   logic                   rsp_fire;
   logic [PHASE_WIDTH:0]   phase_next;
   logic                   roll;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   hit;
   logic [DIV_WIDTH-1:0]   wr_div;
   rsp_type                rsp_new;

   assign op       = req_tuser[OP_WIDTH-1:0];
   assign sel      = req_tuser[REQ_USER_W-1:OP_WIDTH];
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // Prescaler and counter step
   always_comb begin
      phase_next = {1'b0, phase_ff} + 9'd1;
      case (div_ff)
         DIV_16:  roll = (phase_next >= PRE_16);
         DIV_256: roll = (phase_next >= PRE_256);
         default: roll = 1'b1;
      endcase
      count_inc = counter_ff + COUNT_WIDTH'(1);
      hit       = armed_ff && (count_inc == alarm_ff[COUNT_WIDTH-1:0]);
   end

   // Normalized divider code of a control write
   always_comb begin
      wr_div = req_tdata[CTRL_DIV_LO +: DIV_WIDTH];
      if (wr_div != DIV_16 && wr_div != DIV_256) begin
         wr_div = DIV_1;
      end
   end

   // Next state and response of the current request
   always_comb begin
      counter_in = counter_ff;
      phase_in   = phase_ff;
      load_in    = load_ff;
      alarm_in   = alarm_ff;
      enable_in  = enable_ff;
      level_in   = level_ff;
      auto_in    = auto_ff;
      div_in     = div_ff;
      status_in  = status_ff;
      armed_in   = armed_ff;
      rsp_new.rdata     = '0;
      rsp_new.irq_pulse = 1'b0;

      case (op)
         OP_TICK: begin
            if (enable_ff) begin
               if (!roll) begin
                  phase_in = phase_next[PHASE_WIDTH-1:0];
               end else begin
                  phase_in   = '0;
                  counter_in = count_inc;
                  if (hit) begin
                     if (!auto_ff) begin
                        armed_in = 1'b0;
                     end
                     if (level_ff) begin
                        status_in = 1'b1;
                     end else begin
                        rsp_new.irq_pulse = 1'b1;
                     end
                  end
               end
            end
         end
         OP_READ: begin
            case (sel)
               REG_LOAD:  rsp_new.rdata = load_ff;
               REG_COUNT: rsp_new.rdata = DATA_WIDTH'(counter_ff);
               REG_CTRL: begin
                  rsp_new.rdata[CTRL_LEVEL]                = level_ff;
                  rsp_new.rdata[CTRL_DIV_LO +: DIV_WIDTH]  = div_ff;
                  rsp_new.rdata[CTRL_AUTO]                 = auto_ff;
                  rsp_new.rdata[CTRL_EN]                   = enable_ff;
                  rsp_new.rdata[CTRL_STAT]                 = status_ff;
               end
               REG_ALARM: rsp_new.rdata = alarm_ff;
               default:   rsp_new.rdata = '0;
            endcase
         end
         OP_WRITE: begin
            case (sel)
               REG_LOAD: begin
                  load_in    = req_tdata;
                  counter_in = req_tdata[COUNT_WIDTH-1:0];
                  phase_in   = '0;
               end
               REG_CTRL: begin
                  div_in    = wr_div;
                  level_in  = req_tdata[CTRL_LEVEL];
                  auto_in   = req_tdata[CTRL_AUTO];
                  enable_in = req_tdata[CTRL_EN];
                  armed_in  = req_tdata[CTRL_EN];
                  phase_in  = '0;
               end
               REG_ALARM: begin
                  alarm_in = req_tdata;
                  armed_in = 1'b1;
               end
               REG_INTCLR: begin
                  if (req_tdata[INTCLR_BIT]) begin
                     status_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      rsp_new.irq_level = status_in;
   end

   // Output register with skid stage
   always_comb begin
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      main_in     = main_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (rsp_fire) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!main_vld_ff || rsp_fire) begin
         main_vld_in = req_fire;
         main_in     = rsp_new;
      end else if (req_fire) begin
         skid_vld_in = 1'b1;
         skid_in     = rsp_new;
      end
   end

   assign req_tready = !skid_vld_ff;
   assign rsp_tvalid = main_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, main_ff};

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff  <= '0;
         phase_ff    <= '0;
         load_ff     <= '0;
         alarm_ff    <= '0;
         enable_ff   <= 1'b0;
         level_ff    <= 1'b0;
         auto_ff     <= 1'b0;
         div_ff      <= DIV_1;
         status_ff   <= 1'b0;
         armed_ff    <= 1'b0;
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            counter_ff <= counter_in;
            phase_ff   <= phase_in;
            load_ff    <= load_in;
            alarm_ff   <= alarm_in;
            enable_ff  <= enable_in;
            level_ff   <= level_in;
            auto_ff    <= auto_in;
            div_ff     <= div_in;
            status_ff  <= status_in;
            armed_ff   <= armed_in;
         end
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ===== design/pat_checker.sv =====
// ----------------------------------------------------------------------------
// pat_checker
// Port-level checks of the prescaled alarm timer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_checker
   import pat_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // An accepted request always shows up as a pending response
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request left no response");

   // Backpressure only while a response is pending
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request side stalled with nothing pending");

   // Reset empties the response side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

endmodule

bind prescaled_alarm_timer pat_checker u_pat_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the prescaled alarm timer. A directed table covers
// reset values, alarm firing in edge and level mode, interrupt clear and
// divider decoding. Random alarm scenarios and register noise follow. Both
// streams stall at random; every response is checked against the table's
// fixed values where a row sets them, else against a behavioral timer model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pat_pkg::*;

   // Codes the package leaves unnamed
   localparam logic [OP_WIDTH-1:0]  OP_UNDEF   = 2'd3;
   localparam logic [SEL_WIDTH-1:0] REG_SPARE5 = 3'd5;
   localparam logic [SEL_WIDTH-1:0] REG_SPARE6 = 3'd6;

   localparam int CNT_W        = COUNT_WIDTH_DEF;
   localparam int RAND_ITEMS   = 1700;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_PCT     = 28;
   localparam int HOLD1_AT     = 400;
   localparam int HOLD2_AT     = 1800;
   localparam int HOLD_LEN     = 60;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_WIDTH-1:0] req_tdata;   // [31:0] wdata
   logic [REQ_USER_W-1:0] req_tuser;   // [1:0] op, [4:2] reg_sel
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [31:0] rdata, [32] irq_level, [33] irq_pulse

   prescaled_alarm_timer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Timer model state
   logic [CNT_W-1:0]       m_count;
   logic [PHASE_WIDTH-1:0] m_phase;
   logic [DATA_WIDTH-1:0]  m_load;
   logic [DATA_WIDTH-1:0]  m_alarm;
   logic                   m_run;
   logic                   m_level;
   logic                   m_auto;
   logic                   m_stat;
   logic                   m_armed;
   logic [DIV_WIDTH-1:0]   m_div;

   rsp_type pending_rsp_q [$];
   int      n_req;
   int      n_err;
   int      n_cyc;
   logic    calm;
   int      calm_lo;
   int      calm_hi;

   // Directed table row; expected response used only where fixed is set
   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [SEL_WIDTH-1:0]  sel;
      logic [DATA_WIDTH-1:0] wdata;
      logic                  fixed;
      logic [DATA_WIDTH-1:0] exp_rdata;
      logic                  exp_level;
      logic                  exp_pulse;
   } dir_row_type;

   localparam int N_DIR = 25;
   localparam dir_row_type DIR_TAB [N_DIR] = '{
      // everything reads zero after reset
      '{OP_READ,  REG_LOAD,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_READ,  REG_COUNT,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_READ,  REG_CTRL,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_READ,  REG_ALARM,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_READ,  REG_INTCLR, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      // undefined request kind does nothing
      '{OP_UNDEF, REG_SPARE5, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      // tick while disabled
      '{OP_TICK,  REG_LOAD,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      // counter one short of alarm, edge mode, divide by one
      '{OP_WRITE, REG_LOAD,   32'hFFFF_FFFE, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_WRITE, REG_ALARM,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_WRITE, REG_CTRL,   32'h0000_0080, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_TICK,  REG_ALARM,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b1},
      // counter wraps, alarm now disarmed
      '{OP_TICK,  REG_CTRL,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      // level mode with auto rearm
      '{OP_WRITE, REG_CTRL,   32'h0000_00C1, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_WRITE, REG_ALARM,  32'h0000_0002, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_TICK,  REG_LOAD,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_TICK,  REG_LOAD,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
      '{OP_READ,  REG_CTRL,   32'h0000_0000, 1'b1, 32'h0000_01C1, 1'b1, 1'b0},
      // clear needs bit 0
      '{OP_WRITE, REG_INTCLR, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
      '{OP_WRITE, REG_INTCLR, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0, 1'b0},
      // count register is read only
      '{OP_WRITE, REG_COUNT,  32'h1234_5678, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_READ,  REG_COUNT,  32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
      // unknown divider code falls back to divide by one
      '{OP_WRITE, REG_CTRL,   32'h0000_009E, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_READ,  REG_CTRL,   32'h0000_0000, 1'b1, 32'h0000_0080, 1'b0, 1'b0},
      // divide by 256 while disabled, spare register write
      '{OP_WRITE, REG_CTRL,   32'h0000_0008, 1'b0, 32'h0000_0000, 1'b0, 1'b0},
      '{OP_WRITE, REG_SPARE6, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0, 1'b0}
   };

   // Next response of the timer for one request; advances the model state
   function automatic rsp_type predict_timer_rsp(input logic [OP_WIDTH-1:0]   op,
                                                 input logic [SEL_WIDTH-1:0]  sel,
                                                 input logic [DATA_WIDTH-1:0] wdata);
      rsp_type              r;
      logic [PHASE_WIDTH:0] nxt;
      logic [PHASE_WIDTH:0] span;
      logic [DIV_WIDTH-1:0] code;
      r = '0;
      case (op)
         OP_TICK: begin
            if (m_run) begin
               span = (m_div == DIV_16)  ? PRE_16 :
                      (m_div == DIV_256) ? PRE_256 : (PHASE_WIDTH+1)'(1);
               nxt  = {1'b0, m_phase} + 1'b1;
               if (nxt < span) begin
                  m_phase = nxt[PHASE_WIDTH-1:0];
               end else begin
                  m_phase = '0;
                  m_count = m_count + 1'b1;
                  if (m_armed && m_count == m_alarm[CNT_W-1:0]) begin
                     if (!m_auto) m_armed = 1'b0;
                     if (m_level) m_stat = 1'b1;
                     else r.irq_pulse = 1'b1;
                  end
               end
            end
         end
         OP_READ: begin
            case (sel)
               REG_LOAD:  r.rdata = m_load;
               REG_COUNT: r.rdata = DATA_WIDTH'(m_count);
               REG_CTRL: begin
                  r.rdata[CTRL_LEVEL]               = m_level;
                  r.rdata[CTRL_DIV_LO +: DIV_WIDTH] = m_div;
                  r.rdata[CTRL_AUTO]                = m_auto;
                  r.rdata[CTRL_EN]                  = m_run;
                  r.rdata[CTRL_STAT]                = m_stat;
               end
               REG_ALARM: r.rdata = m_alarm;
               default:   r.rdata = '0;
            endcase
         end
         OP_WRITE: begin
            case (sel)
               REG_LOAD: begin
                  m_load  = wdata;
                  m_count = wdata[CNT_W-1:0];
                  m_phase = '0;
               end
               REG_CTRL: begin
                  code    = wdata[CTRL_DIV_LO +: DIV_WIDTH];
                  m_div   = (code == DIV_16 || code == DIV_256) ? code : DIV_1;
                  m_level = wdata[CTRL_LEVEL];
                  m_auto  = wdata[CTRL_AUTO];
                  m_run   = wdata[CTRL_EN];
                  m_armed = wdata[CTRL_EN];
                  m_phase = '0;
               end
               REG_ALARM: begin
                  m_alarm = wdata;
                  m_armed = 1'b1;
               end
               REG_INTCLR: begin
                  if (wdata[INTCLR_BIT]) m_stat = 1'b0;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.irq_level = m_stat;
      return r;
   endfunction

   // Offer one request, wait for the handshake, then queue its response
   task automatic offer_request(input logic [OP_WIDTH-1:0]   op,
                                input logic [SEL_WIDTH-1:0]  sel,
                                input logic [DATA_WIDTH-1:0] wdata,
                                input logic                  fixed = 1'b0,
                                input rsp_type               fixed_rsp = '0);
      rsp_type pred;
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= wdata;
      req_tuser  <= {sel, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_timer_rsp(op, sel, wdata);
      pending_rsp_q.push_back(fixed ? fixed_rsp : pred);
      if (op != OP_UNDEF) n_req++;
      calm = (n_req >= calm_lo && n_req < calm_hi);
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic random_tick();
      offer_request(OP_TICK, SEL_WIDTH'($urandom), $urandom);
   endtask

   // Load, arm, then tick up to (and a little past) the alarm
   task automatic alarm_scenario();
      logic [DATA_WIDTH-1:0] start;
      logic [DATA_WIDTH-1:0] ctrl;
      logic [DIV_WIDTH-1:0]  code;
      int unsigned           span;
      int unsigned           steps;
      int unsigned           ticks;
      int unsigned           back;
      int unsigned           r;
      r = $urandom_range(99);
      if (r < 65) begin
         do code = DIV_WIDTH'($urandom); while (code == DIV_16 || code == DIV_256);
         span = 1;
      end else if (r < 97) begin
         code = DIV_16;
         span = 16;
      end else begin
         code = DIV_256;
         span = 256;
      end
      steps = (span == 256) ? 1 : $urandom_range(1, 12);
      if ($urandom_range(3) == 0) start = '1 - DATA_WIDTH'($urandom_range(10));
      else start = $urandom;
      ctrl = $urandom;
      ctrl[CTRL_DIV_LO +: DIV_WIDTH] = code;
      ctrl[CTRL_EN] = 1'b1;

      offer_request(OP_WRITE, REG_LOAD, start);
      // either order arms the alarm
      if ($urandom_range(1) == 1) begin
         offer_request(OP_WRITE, REG_CTRL, ctrl);
         offer_request(OP_WRITE, REG_ALARM, start + steps);
      end else begin
         offer_request(OP_WRITE, REG_ALARM, start + steps);
         offer_request(OP_WRITE, REG_CTRL, ctrl);
      end

      ticks = steps * span + $urandom_range(0, 3);
      for (int i = 0; i < ticks; i++) begin
         r = $urandom_range(99);
         if (r < 8) offer_request(OP_READ, SEL_WIDTH'($urandom), $urandom);
         else if (r < 10) offer_request(OP_WRITE, REG_INTCLR, $urandom);
         random_tick();
      end

      // reload below the alarm: fires again only with auto rearm
      if (span == 1 && $urandom_range(1) == 1) begin
         back = $urandom_range(1, 4);
         offer_request(OP_WRITE, REG_LOAD, start + steps - back);
         repeat (back + 1) random_tick();
      end
      if ($urandom_range(1) == 1) offer_request(OP_READ, REG_CTRL, $urandom);
      if ($urandom_range(1) == 1) begin
         offer_request(OP_WRITE, REG_INTCLR, $urandom | (32'd1 << INTCLR_BIT));
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle limit
   initial n_cyc = 0;
   always @(posedge clock) begin
      n_cyc++;
      if (n_cyc >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Response side: random stalls, two long hold-offs
   initial begin
      int unsigned rx_cyc;
      rx_cyc     = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cyc++;
         if ((rx_cyc >= HOLD1_AT && rx_cyc < HOLD1_AT + HOLD_LEN) ||
             (rx_cyc >= HOLD2_AT && rx_cyc < HOLD2_AT + HOLD_LEN)) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Response check
   initial n_err = 0;
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         if (pending_rsp_q.size() == 0) begin
            $error("response %h with no request pending", rsp_tdata);
            n_err++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.rdata !== want.rdata) begin
               $error("rdata: expected %h, got %h", want.rdata, got.rdata);
               n_err++;
            end
            if (got.irq_level !== want.irq_level) begin
               $error("irq_level: expected %b, got %b", want.irq_level, got.irq_level);
               n_err++;
            end
            if (got.irq_pulse !== want.irq_pulse) begin
               $error("irq_pulse: expected %b, got %b", want.irq_pulse, got.irq_pulse);
               n_err++;
            end
            if (rsp_tdata[RSP_DATA_W-1:$bits(rsp_type)] !== '0) begin
               $error("pad: expected 0, got %h", rsp_tdata[RSP_DATA_W-1:$bits(rsp_type)]);
               n_err++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      rsp_type fr;
      logic    paused;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      n_req      = 0;
      calm       = 1'b0;
      calm_lo    = N_DIR + 300;
      calm_hi    = N_DIR + 600;
      paused     = 1'b0;
      m_count    = '0;
      m_phase    = '0;
      m_load     = '0;
      m_alarm    = '0;
      m_run      = 1'b0;
      m_level    = 1'b0;
      m_auto     = 1'b0;
      m_stat     = 1'b0;
      m_armed    = 1'b0;
      m_div      = DIV_1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_DIR; i++) begin
         fr.rdata     = DIR_TAB[i].exp_rdata;
         fr.irq_level = DIR_TAB[i].exp_level;
         fr.irq_pulse = DIR_TAB[i].exp_pulse;
         offer_request(DIR_TAB[i].op, DIR_TAB[i].sel, DIR_TAB[i].wdata,
                       DIR_TAB[i].fixed, fr);
      end

      // random scenarios and noise
      while (n_req < N_DIR + RAND_ITEMS) begin
         if (!paused && n_req >= N_DIR + 1000) begin
            // sender pause: let the block drain completely
            idle_sender();
            while (pending_rsp_q.size() != 0) @(posedge clock);
            paused = 1'b1;
         end
         if ($urandom_range(99) < 70) begin
            alarm_scenario();
         end else begin
            repeat ($urandom_range(3, 12)) begin
               offer_request(OP_WIDTH'($urandom), SEL_WIDTH'($urandom), $urandom);
            end
         end
      end

      idle_sender();
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_err == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/pat_pkg.sv
design/prescaled_alarm_timer.sv
design/pat_checker.sv
sim/tb_top.sv
